// ===== src/h264_rtp_payload_depacketizer_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef H264_RTP_PAYLOAD_DEPACKETIZER_CORE_ASSERT_SVH
`define H264_RTP_PAYLOAD_DEPACKETIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define H264RTP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("h264rtp: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define H264RTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("h264rtp: next-cycle check failed");

`endif

// ===== src/h264rtp_pkg.sv =====
`timescale 1ns / 1ps

package h264rtp_pkg;

   // Packets longer than this are treated as this long.
   localparam logic [12:0] MAX_PACKET = 13'd4096;

   localparam logic [4:0] NAL_SINGLE_MAX = 5'd23;
   localparam logic [4:0] NAL_STAP_A     = 5'd24;
   localparam logic [4:0] NAL_FU_A       = 5'd28;
   localparam logic [4:0] NAL_FU_B       = 5'd29;

   localparam logic [2:0] KIND_NONE   = 3'd0;
   localparam logic [2:0] KIND_SINGLE = 3'd1;
   localparam logic [2:0] KIND_STAP_A = 3'd2;
   localparam logic [2:0] KIND_FU_A   = 3'd3;
   localparam logic [2:0] KIND_FU_B   = 3'd4;
   localparam logic [2:0] KIND_UNSUP  = 3'd5;

   localparam logic [12:0] POS_MAX   = 13'h1FFF;
   localparam logic [10:0] UNITS_MAX = 11'h7FF;

   typedef enum logic [3:0] {
      AGG_LEN_HI = 4'b0001,
      AGG_LEN_LO = 4'b0010,
      AGG_DATA   = 4'b0100,
      AGG_STOP   = 4'b1000
   } agg_phase_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [12:0] packet_length;
      logic        packet_last;
   } req_item_type;

   typedef struct packed {
      logic        out_valid_data;
      logic [7:0]  out_byte;
      logic        unit_first;
      logic        unit_final;
      logic [4:0]  unit_type;
      logic        packet_done;
      logic [2:0]  packet_kind;
      logic        packet_ok;
      logic        fragment_start;
      logic        fragment_end;
      logic [10:0] unit_count;
   } rsp_item_type;

   // Per-packet parse state; fft bit6 start, bit5 end (STAP-A: unit start
   // pending), bits 4..0 NAL type.
   typedef struct packed {
      logic [12:0]   byte_position;
      logic [2:0]    kind_held;
      agg_phase_type aggregate_phase;
      logic [7:0]    length_high_byte;
      logic [15:0]   unit_bytes_left;
      logic [6:0]    fragment_flags_type;
      logic [10:0]   units_found;
   } parse_state_type;

   localparam parse_state_type STATE_CLEAR = '{
      byte_position:       13'd0,
      kind_held:           KIND_NONE,
      aggregate_phase:     AGG_LEN_HI,
      length_high_byte:    8'd0,
      unit_bytes_left:     16'd0,
      fragment_flags_type: 7'd0,
      units_found:         11'd0
   };

endpackage

// ===== src/h264rtp_parse.sv =====
`timescale 1ns / 1ps

// Per-byte parse: next state, result and whether a result is produced.
module h264rtp_parse import h264rtp_pkg::*; (
   input  req_item_type    item,
   input  parse_state_type cur,
   output parse_state_type nxt,
   output logic            has_result,
   output rsp_item_type    result
);

   logic [12:0] len;
   logic [12:0] pos;
   logic [7:0]  b;
   logic [4:0]  t;
   logic        emit;
   logic        first;
   logic        final_byte;
   logic        fs;
   logic        fe;
   logic [4:0]  utype;
   logic [15:0] ul;
   logic [15:0] ubl_dec;
   logic [16:0] need;
   logic [12:0] data_start;
   logic        pos_is_last;
   parse_state_type upd;
   logic [2:0]  kind;
   logic [10:0] count;

   always_comb begin
      len         = (item.packet_length > MAX_PACKET) ? MAX_PACKET : item.packet_length;
      pos         = cur.byte_position;
      b           = item.data_byte;
      t           = b[4:0];
      pos_is_last = ({1'b0, pos} + 14'd1) == {1'b0, len};
      ul          = {cur.length_high_byte, b};
      need        = {4'd0, pos} + 17'd1 + {1'b0, ul};
      ubl_dec     = (cur.unit_bytes_left != 16'd0) ? cur.unit_bytes_left - 16'd1
                                                   : cur.unit_bytes_left;
      data_start  = (cur.kind_held == KIND_FU_A) ? 13'd2 : 13'd4;
      upd         = cur;
      emit        = 1'b0;
      first       = 1'b0;
      final_byte  = 1'b0;
      fs          = 1'b0;
      fe          = 1'b0;
      utype       = 5'd0;

      if (pos < len) begin
         if (pos == 13'd0) begin
            if (t >= 5'd1 && t <= NAL_SINGLE_MAX) begin
               upd.kind_held           = KIND_SINGLE;
               upd.fragment_flags_type = {2'b00, t};
               emit                    = 1'b1;
               first                   = 1'b1;
               final_byte              = (len == 13'd1);
               utype                   = t;
            end else if (t == NAL_STAP_A) begin
               upd.kind_held       = KIND_STAP_A;
               upd.aggregate_phase = AGG_LEN_HI;
            end else if (t == NAL_FU_A) begin
               upd.kind_held = (len >= 13'd2) ? KIND_FU_A : KIND_NONE;
            end else if (t == NAL_FU_B) begin
               upd.kind_held = (len >= 13'd4) ? KIND_FU_B : KIND_NONE;
            end else begin
               upd.kind_held = KIND_UNSUP;
            end
         end else if (cur.kind_held == KIND_SINGLE) begin
            emit       = 1'b1;
            final_byte = pos_is_last;
            utype      = cur.fragment_flags_type[4:0];
         end else if (cur.kind_held == KIND_FU_A || cur.kind_held == KIND_FU_B) begin
            if (pos == 13'd1) begin
               upd.fragment_flags_type = {b[7], b[6], b[4:0]};
            end
            if (pos >= data_start) begin
               emit       = 1'b1;
               first      = (pos == data_start);
               final_byte = pos_is_last;
               utype      = upd.fragment_flags_type[4:0];
               fs         = upd.fragment_flags_type[6];
               fe         = upd.fragment_flags_type[5];
            end
         end else if (cur.kind_held == KIND_STAP_A) begin
            unique case (cur.aggregate_phase)
               AGG_LEN_HI: begin
                  if (!pos_is_last) begin
                     upd.length_high_byte = b;
                     upd.aggregate_phase  = AGG_LEN_LO;
                  end else begin
                     upd.aggregate_phase = AGG_STOP;
                  end
               end
               AGG_LEN_LO: begin
                  if (ul == 16'd0 || need > {4'd0, len}) begin
                     upd.aggregate_phase = AGG_STOP;
                  end else begin
                     upd.unit_bytes_left     = ul;
                     upd.units_found         = (cur.units_found != UNITS_MAX)
                                               ? cur.units_found + 11'd1
                                               : cur.units_found;
                     upd.fragment_flags_type = 7'h20;
                     upd.aggregate_phase     = AGG_DATA;
                  end
               end
               AGG_DATA: begin
                  if (cur.fragment_flags_type[5]) begin
                     upd.fragment_flags_type = {2'b00, b[4:0]};
                     first                   = 1'b1;
                  end
                  emit                = 1'b1;
                  utype               = upd.fragment_flags_type[4:0];
                  final_byte          = (cur.unit_bytes_left == 16'd1);
                  upd.unit_bytes_left = ubl_dec;
                  if (ubl_dec == 16'd0) begin
                     upd.aggregate_phase = AGG_LEN_HI;
                  end
               end
               AGG_STOP: begin
               end
               default: begin
               end
            endcase
         end
      end

      if (pos != POS_MAX) begin
         upd.byte_position = pos + 13'd1;
      end

      kind  = KIND_NONE;
      count = 11'd0;
      if (item.packet_last) begin
         kind = upd.kind_held;
         if (kind == KIND_STAP_A) begin
            if (upd.units_found == 11'd0) begin
               kind = KIND_NONE;
            end else begin
               count = upd.units_found;
            end
         end
         if (kind == KIND_FU_A || kind == KIND_FU_B) begin
            fs = upd.fragment_flags_type[6];
            fe = upd.fragment_flags_type[5];
         end
      end

      has_result             = emit | item.packet_last;
      result.out_valid_data  = emit;
      result.out_byte        = emit ? b : 8'd0;
      result.unit_first      = emit & first;
      result.unit_final      = emit & final_byte;
      result.unit_type       = emit ? utype : 5'd0;
      result.packet_done     = item.packet_last;
      result.packet_kind     = kind;
      result.packet_ok       = (kind >= KIND_SINGLE) && (kind <= KIND_FU_B);
      result.fragment_start  = fs;
      result.fragment_end    = fe;
      result.unit_count      = count;

      nxt = item.packet_last ? STATE_CLEAR : upd;
   end

endmodule

// ===== src/h264_rtp_payload_depacketizer_core.sv =====
`timescale 1ns / 1ps

// H.264 RTP payload depacketizer (RFC 6184 single NAL, STAP-A, FU-A, FU-B).
// Request channel (req_): one payload byte per transfer with the packet
// length and a flag on the final byte. Response channel (rsp_): zero or one
// result per byte - a data byte of a NAL unit or fragment, and/or the packet
// status on the final byte. Bytes that carry only headers, lengths or a DON
// give no result.
// A taken byte passes the input register, then the result register, on its
// way to rsp_. Throughput: one byte per cycle while the receiver does not
// stall, set by the single parse step between the two registers.
// Reset (synchronous, active high) empties both registers and clears the
// packet state. When the receiver stalls, the result register holds; a byte
// that gives no result still drains from the input register, and the
// request side is stalled only while a result-bearing byte waits there.
module h264_rtp_payload_depacketizer_core import h264rtp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   logic            in_valid_ff, in_valid_in;
   req_item_type    in_item_ff;
   parse_state_type state_ff, state_in;
   logic            out_valid_ff, out_valid_in;
   rsp_item_type    out_item_ff;

   parse_state_type state_nxt;
   logic            has_result;
   rsp_item_type    result;
   logic            out_free;
   logic            in_fire;
   logic            req_take;

   h264rtp_parse u_parse (
      .item       (in_item_ff),
      .cur        (state_ff),
      .nxt        (state_nxt),
      .has_result (has_result),
      .result     (result)
   );

   // Advance the held byte when its result has room, or when it makes none.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_fire   = in_valid_ff && (out_free || !has_result);
   assign req_stall = in_valid_ff && !in_fire;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (in_fire ? 1'b0 : in_valid_ff);
      state_in     = in_fire ? state_nxt : state_ff;
      out_valid_in = (in_fire && has_result) ? 1'b1
                   : (out_valid_ff && !rsp_stall) ? 1'b0 : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= STATE_CLEAR;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load on transfer, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_data;
      end
      if (in_fire && has_result) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

endmodule

// ===== src/h264rtp_checker.sv =====
`timescale 1ns / 1ps
`include "h264_rtp_payload_depacketizer_core_assert.svh"

module h264rtp_checker import h264rtp_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_data
);

   logic rsp_status_only;
   logic rsp_data_clear;
   logic rsp_status_clear;
   logic rsp_kind_ok;

   assign rsp_status_only  = rsp_valid && !rsp_data.out_valid_data;
   assign rsp_data_clear   = !rsp_data.unit_first && !rsp_data.unit_final
                             && rsp_data.unit_type == 5'd0 && rsp_data.out_byte == 8'd0;
   assign rsp_status_clear = rsp_data.packet_kind == KIND_NONE && !rsp_data.packet_ok
                             && rsp_data.unit_count == 11'd0;
   assign rsp_kind_ok      = rsp_data.packet_kind == KIND_SINGLE
                             || rsp_data.packet_kind == KIND_STAP_A
                             || rsp_data.packet_kind == KIND_FU_A
                             || rsp_data.packet_kind == KIND_FU_B;

   `H264RTP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `H264RTP_ASSERT_IMPL(a_rsp_has_content, clock, reset, rsp_status_only, rsp_data.packet_done)
   `H264RTP_ASSERT_IMPL(a_status_only_done, clock, reset, rsp_valid && !rsp_data.packet_done, rsp_status_clear)
   `H264RTP_ASSERT_IMPL(a_ok_kind, clock, reset, rsp_valid && rsp_data.packet_ok, rsp_kind_ok)
   `H264RTP_ASSERT_IMPL(a_no_data_zero, clock, reset, rsp_status_only, rsp_data_clear)

endmodule

bind h264_rtp_payload_depacketizer_core h264rtp_checker u_checker (.*);

// ===== tb/sv/depacketizer_scoreboard_pkg.sv =====
`timescale 1ns / 1ps

package depacketizer_scoreboard_pkg;
   import h264rtp_pkg::*;

   class nal_byte_scoreboard;
      logic [12:0]   pos;
      logic [2:0]    kind;
      agg_phase_type phase;
      logic [7:0]    len_hi;
      logic [15:0]   bytes_left;
      logic [6:0]    flags_type;
      logic [10:0]   units;

      rsp_item_type  expected_results[$];
      int unsigned   fail_count;
      int unsigned   checked_count;
      int unsigned   packets_done;
      int unsigned   most_units;
      int unsigned   kind_tally[8];

      function new();
         fail_count    = 0;
         checked_count = 0;
         packets_done  = 0;
         most_units    = 0;
         foreach (kind_tally[i]) kind_tally[i] = 0;
         clear_packet();
      endfunction

      function void clear_packet();
         pos        = '0;
         kind       = KIND_NONE;
         phase      = AGG_LEN_HI;
         len_hi     = '0;
         bytes_left = '0;
         flags_type = '0;
         units      = '0;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // Advance the parse state by one accepted byte; queue its result, if any.
      function void note_byte(req_item_type item);
         int unsigned  eff_len;
         int unsigned  p;
         int unsigned  unit_len;
         int unsigned  fu_skip;
         logic [7:0]   b;
         logic [4:0]   nal;
         logic [4:0]   ty;
         logic [2:0]   k;
         logic         emit;
         logic         first;
         logic         unit_end;
         logic         fs;
         logic         fe;
         rsp_item_type r;

         b        = item.data_byte;
         eff_len  = 32'((item.packet_length > MAX_PACKET) ? MAX_PACKET
                                                          : item.packet_length);
         p        = 32'(pos);
         emit     = 1'b0;
         first    = 1'b0;
         unit_end = 1'b0;
         fs       = 1'b0;
         fe       = 1'b0;
         ty       = '0;

         if (p < eff_len) begin
            if (p == 0) begin
               nal = b[4:0];
               if (nal >= 5'd1 && nal <= NAL_SINGLE_MAX) begin
                  kind       = KIND_SINGLE;
                  flags_type = {2'b00, nal};
                  emit       = 1'b1;
                  first      = 1'b1;
                  unit_end   = (eff_len == 1);
                  ty         = nal;
               end else if (nal == NAL_STAP_A) begin
                  kind  = KIND_STAP_A;
                  phase = AGG_LEN_HI;
               end else if (nal == NAL_FU_A) begin
                  kind = (eff_len >= 2) ? KIND_FU_A : KIND_NONE;
               end else if (nal == NAL_FU_B) begin
                  kind = (eff_len >= 4) ? KIND_FU_B : KIND_NONE;
               end else begin
                  kind = KIND_UNSUP;
               end
            end else if (kind == KIND_SINGLE) begin
               emit     = 1'b1;
               unit_end = (p == eff_len - 1);
               ty       = flags_type[4:0];
            end else if (kind == KIND_FU_A || kind == KIND_FU_B) begin
               fu_skip = (kind == KIND_FU_A) ? 2 : 4;
               if (p == 1) flags_type = {b[7], b[6], b[4:0]};
               if (p >= fu_skip) begin
                  emit     = 1'b1;
                  first    = (p == fu_skip);
                  unit_end = (p == eff_len - 1);
                  ty       = flags_type[4:0];
                  fs       = flags_type[6];
                  fe       = flags_type[5];
               end
            end else if (kind == KIND_STAP_A) begin
               case (phase)
                  AGG_LEN_HI: begin
                     if (p + 1 < eff_len) begin
                        len_hi = b;
                        phase  = AGG_LEN_LO;
                     end else begin
                        phase = AGG_STOP;
                     end
                  end
                  AGG_LEN_LO: begin
                     unit_len = 32'({len_hi, b});
                     if (unit_len == 0 || p + 1 + unit_len > eff_len) begin
                        phase = AGG_STOP;
                     end else begin
                        bytes_left = 16'(unit_len);
                        if (units != UNITS_MAX) units = units + 11'd1;
                        flags_type = 7'h20;
                        phase      = AGG_DATA;
                     end
                  end
                  AGG_DATA: begin
                     if (flags_type[5]) begin
                        flags_type = {2'b00, b[4:0]};
                        first      = 1'b1;
                     end
                     emit     = 1'b1;
                     ty       = flags_type[4:0];
                     unit_end = (bytes_left == 16'd1);
                     if (bytes_left != 0) bytes_left = bytes_left - 16'd1;
                     if (bytes_left == 0) phase = AGG_LEN_HI;
                  end
                  default: ;
               endcase
            end
         end

         if (pos != POS_MAX) pos = pos + 13'd1;

         if (!emit && !item.packet_last) return;

         r = '0;
         if (emit) begin
            r.out_valid_data = 1'b1;
            r.out_byte       = b;
            r.unit_first     = first;
            r.unit_final     = unit_end;
            r.unit_type      = ty;
         end
         if (item.packet_last) begin
            k = kind;
            if (k == KIND_STAP_A) begin
               if (units == 0) k = KIND_NONE;
               else r.unit_count = units;
               if (32'(units) > most_units) most_units = 32'(units);
            end
            r.packet_done = 1'b1;
            r.packet_kind = k;
            r.packet_ok   = (k >= KIND_SINGLE && k <= KIND_FU_B);
            if (k == KIND_FU_A || k == KIND_FU_B) begin
               fs = flags_type[6];
               fe = flags_type[5];
            end
            kind_tally[k]++;
            packets_done++;
            clear_packet();
         end
         r.fragment_start = fs;
         r.fragment_end   = fe;
         expected_results = {expected_results, r};
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (expected_results.size() == 0) begin
            $error("result with nothing outstanding: %h", got);
            fail_count++;
            return;
         end
         want = expected_results.pop_front();
         checked_count++;
         compare_field("out_valid_data", want.out_valid_data, got.out_valid_data);
         compare_field("out_byte",       want.out_byte,       got.out_byte);
         compare_field("unit_first",     want.unit_first,     got.unit_first);
         compare_field("unit_final",     want.unit_final,     got.unit_final);
         compare_field("unit_type",      want.unit_type,      got.unit_type);
         compare_field("packet_done",    want.packet_done,    got.packet_done);
         compare_field("packet_kind",    want.packet_kind,    got.packet_kind);
         compare_field("packet_ok",      want.packet_ok,      got.packet_ok);
         compare_field("fragment_start", want.fragment_start, got.fragment_start);
         compare_field("fragment_end",   want.fragment_end,   got.fragment_end);
         compare_field("unit_count",     want.unit_count,     got.unit_count);
      endfunction
   endclass

endpackage

// ===== tb/sv/tb_h264_rtp_payload_depacketizer_core.sv =====
`timescale 1ns / 1ps

module tb_h264_rtp_payload_depacketizer_core;
   import h264rtp_pkg::*;
   import depacketizer_scoreboard_pkg::*;

   // NAL types that the block must report as unsupported.
   localparam logic [4:0] NAL_UNSPEC   = 5'd0;
   localparam logic [4:0] NAL_STAP_B   = 5'd25;
   localparam logic [4:0] NAL_MTAP16   = 5'd26;
   localparam logic [4:0] NAL_MTAP24   = 5'd27;
   localparam logic [4:0] NAL_RESVD_30 = 5'd30;
   localparam logic [4:0] NAL_RESVD_31 = 5'd31;

   localparam int unsigned RANDOM_BYTES = 600;

   // How a STAP-A packet ends after its well-formed units.
   typedef enum int unsigned {
      TAIL_NONE,
      TAIL_ZERO_LEN,
      TAIL_OVERRUN,
      TAIL_STRAY_BYTE
   } stap_tail_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;

   nal_byte_scoreboard sb = new();

   // Bytes of the packet being built; the builders append, send_packet sends them.
   logic [7:0]  payload[$];
   int unsigned bytes_sent  = 0;
   int unsigned sender_idle = 0;

   // Receiver stall pattern: the mode is redrawn when its countdown runs out.
   int unsigned rsp_mode    = 0;
   int unsigned mode_left   = 0;
   int unsigned stall_burst = 0;

   always #10 clock = ~clock;

   h264_rtp_payload_depacketizer_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Take each result transfer into the scoreboard, then decide the stall for
   // the next cycle. Values read here are the ones present before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_data);
      if (mode_left == 0) begin
         rsp_mode  = $urandom_range(0, 3);
         mode_left = $urandom_range(50, 400);
      end else begin
         mode_left--;
      end
      if (stall_burst != 0) begin
         stall_burst--;
         rsp_stall <= 1'b1;
      end else if (rsp_mode == 1 && $urandom_range(0, 99) < 15) begin
         stall_burst = $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else if (rsp_mode == 2 && $urandom_range(0, 99) < 35) begin
         stall_burst = $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else if (rsp_mode == 3 && $urandom_range(0, 99) < 4) begin
         stall_burst = $urandom_range(4, 29);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Send every byte in payload as one packet with the given length field.
   // The last-flag rides on the final byte, whatever the length says.
   task automatic send_packet(input logic [12:0] plen);
      int unsigned  i;
      int unsigned  gap;
      int unsigned  r;
      req_item_type item;
      for (i = 0; i < payload.size(); i++) begin
         item.data_byte     = payload[i];
         item.packet_length = plen;
         item.packet_last   = (i == payload.size() - 1);
         // Mostly back-to-back; a few short gaps and now and then a long one.
         gap = 0;
         if (sender_idle != 0) begin
            r = $urandom_range(0, 99);
            if (r >= ((sender_idle == 1) ? 80 : 60)) begin
               if (r < 95) gap = $urandom_range(1, 3);
               else gap = (sender_idle == 3) ? $urandom_range(8, 40) : $urandom_range(4, 8);
            end
         end
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= item;
         // Hold the byte until the block takes it.
         do @(posedge clock); while (!(req_valid && !req_stall));
         sb.note_byte(item);
         bytes_sent++;
      end
   endtask

   // Drop valid and hold off until every outstanding result has been seen.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Append one byte to the packet under construction.
   function automatic void append_byte(logic [7:0] v);
      payload = {payload, v};
   endfunction

   function automatic void build_nal_unit(int unsigned n);
      logic [7:0] hdr;
      hdr      = 8'($urandom);
      hdr[4:0] = 5'($urandom_range(1, NAL_SINGLE_MAX));
      append_byte(hdr);
      repeat (n - 1) append_byte(8'($urandom));
   endfunction

   // Aggregation packet: n_units well-formed units of up to max_size bytes,
   // mostly tiny so that length fields and unit boundaries come thick and fast.
   function automatic void build_stap(int unsigned n_units, int unsigned max_size,
                                      stap_tail_type tail);
      logic [7:0]  hdr;
      logic [15:0] size;
      int unsigned extra;
      hdr      = 8'($urandom);
      hdr[4:0] = NAL_STAP_A;
      append_byte(hdr);
      repeat (n_units) begin
         if (max_size > 6 && $urandom_range(0, 19) == 0)
            size = 16'($urandom_range(7, max_size));
         else
            size = 16'($urandom_range(1, (max_size < 6) ? max_size : 6));
         append_byte(size[15:8]);
         append_byte(size[7:0]);
         repeat (size) append_byte(8'($urandom));
      end
      case (tail)
         TAIL_ZERO_LEN: begin
            append_byte(8'h00);
            append_byte(8'h00);
            repeat ($urandom_range(0, 4)) append_byte(8'($urandom));
         end
         TAIL_OVERRUN: begin
            // Claim more bytes than remain in the packet.
            size  = 16'($urandom_range(1, 16'hFFFF));
            extra = $urandom_range(0, (size > 4) ? 4 : size - 1);
            append_byte(size[15:8]);
            append_byte(size[7:0]);
            repeat (extra) append_byte(8'($urandom));
         end
         TAIL_STRAY_BYTE: append_byte(8'($urandom));
         default: ;
      endcase
   endfunction

   function automatic void build_fu(logic [4:0] fu_type, int unsigned n);
      logic [7:0] hdr;
      hdr      = 8'($urandom);
      hdr[4:0] = fu_type;
      append_byte(hdr);
      append_byte(8'($urandom));
      if (fu_type == NAL_FU_B) begin
         append_byte(8'($urandom));
         append_byte(8'($urandom));
      end
      repeat (n) append_byte(8'($urandom));
   endfunction

   initial begin
      logic [12:0] plen;
      logic [7:0]  hdr;
      int unsigned random_end;
      int unsigned r;
      int unsigned cut;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed packets: one of each kind and the awkward corners.
      sender_idle = 1;
      // single NAL of one byte: first and final together
      payload = '{8'h65};
      send_packet(13'd1);
      // unsupported type, all-zero byte
      payload = '{8'h00};
      send_packet(13'd1);
      // unsupported type, all-ones byte and length, final byte far too early
      payload = '{8'hFF};
      send_packet(13'h1FFF);
      // zero length: nothing decoded
      payload = '{8'h41};
      send_packet(13'd0);
      // single NAL with a byte beyond its length
      payload = '{8'h67, 8'hAA, 8'h55};
      send_packet(13'd2);
      // STAP-A with one unit and a zero-length trailer
      payload = '{8'h18, 8'h00, 8'h01, 8'h06, 8'h00, 8'h00};
      send_packet(13'd6);
      // STAP-A with no units at all
      payload = '{8'h78, 8'h00, 8'h00};
      send_packet(13'd3);
      // FU-A and FU-B too short for their headers
      payload = '{8'h7C};
      send_packet(13'd1);
      payload = '{8'h1D, 8'h45, 8'h00};
      send_packet(13'd3);
      // FU-A with a header but no fragment bytes
      payload = '{8'h5C, 8'h85};
      send_packet(13'd2);
      // FU-B with start and end set and a single fragment byte
      payload = '{8'h3D, 8'hC1, 8'h12, 8'h34, 8'h9A};
      send_packet(13'd5);

      // Force a full drain at least once before the random traffic.
      drain_results();

      random_end = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < random_end) begin
         sender_idle = $urandom_range(0, 3);
         if ($urandom_range(0, 24) == 0) drain_results();
         payload.delete();
         r = $urandom_range(0, 99);
         if (r < 20) begin
            build_nal_unit(($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                       : $urandom_range(1, 16));
         end else if (r < 45) begin
            build_stap(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4), 300,
                       stap_tail_type'($urandom_range(0, 3)));
         end else if (r < 62) begin
            build_fu(NAL_FU_A, ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 12));
         end else if (r < 78) begin
            build_fu(NAL_FU_B, ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 12));
         end else if (r < 86) begin
            hdr = 8'($urandom);
            case ($urandom_range(0, 5))
               0:       hdr[4:0] = NAL_UNSPEC;
               1:       hdr[4:0] = NAL_STAP_B;
               2:       hdr[4:0] = NAL_MTAP16;
               3:       hdr[4:0] = NAL_MTAP24;
               4:       hdr[4:0] = NAL_RESVD_30;
               default: hdr[4:0] = NAL_RESVD_31;
            endcase
            append_byte(hdr);
            repeat ($urandom_range(0, 8)) append_byte(8'($urandom));
         end else begin
            repeat ($urandom_range(1, 12)) append_byte(8'($urandom));
         end

         // Break about one packet in five: wrong length or an early final byte.
         plen = 13'(payload.size());
         case ($urandom_range(0, 19))
            0: plen = 13'($urandom_range(0, payload.size() - 1));
            1: plen = 13'(payload.size() + $urandom_range(1, 40));
            2: plen = 13'($urandom_range(MAX_PACKET + 1, POS_MAX));
            3: begin
               if (payload.size() > 1) begin
                  cut = $urandom_range(1, payload.size() - 1);
                  repeat (cut) void'(payload.pop_back());
               end
            end
            default: ;
         endcase
         send_packet(plen);
      end

      // Long aggregation packet: many one-byte units back to back.
      sender_idle = $urandom_range(0, 2);
      payload.delete();
      build_stap(30, 1, TAIL_NONE);
      send_packet(13'(payload.size()));

      drain_results();
      repeat (8) @(posedge clock);

      $display("Covered %0d packets over %0d bytes: single %0d, STAP-A %0d, FU-A %0d,",
               sb.packets_done, bytes_sent, sb.kind_tally[KIND_SINGLE],
               sb.kind_tally[KIND_STAP_A], sb.kind_tally[KIND_FU_A]);
      $display("  FU-B %0d, unsupported %0d, none %0d; %0d results, up to %0d units",
               sb.kind_tally[KIND_FU_B], sb.kind_tally[KIND_UNSUP],
               sb.kind_tally[KIND_NONE], sb.checked_count, sb.most_units);
      if (sb.fail_count == 0 && sb.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #(50_000_000);
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== h264_rtp_payload_depacketizer_core.f =====
+incdir+src
src/h264rtp_pkg.sv
src/h264rtp_parse.sv
src/h264_rtp_payload_depacketizer_core.sv
src/h264rtp_checker.sv
tb/sv/depacketizer_scoreboard_pkg.sv
tb/sv/tb_h264_rtp_payload_depacketizer_core.sv
